/* sv/hkm_pkg.sv */
// ---------------------------------------------------------------------------
// hkm_pkg: shared types and constants of the k-mismatch matcher
// Symbol and count widths, register indexes, item codes and the control
// group that the top level hands to every cell of the chain.
// ---------------------------------------------------------------------------
package hkm_pkg;

   localparam int SYM_W       = 8;
   localparam int CNT_W       = 7;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

   // input selector and result kind codes
   localparam logic MODE_PATTERN = 1'b0;
   localparam logic MODE_TEXT    = 1'b1;
   localparam logic KIND_MATCH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_PATTERN_LENGTH  = 2'd0,
      REG_MATCH_THRESHOLD = 2'd1,
      REG_MAX_THRESHOLD   = 2'd2,
      REG_SEPARATOR_CODE  = 2'd3
   } reg_idx_type;

   // control broadcast to every cell
   typedef struct packed {
      logic             shift;   // text item accepted: windows advance one cell
      logic             clear;   // end of text: windows return to reset state
      logic             is_sep;  // incoming text symbol is the separator
      logic [SYM_W-1:0] sym;     // incoming symbol (text or pattern)
   } cell_ctrl_type;

endpackage

/* sv/hamming_k_mismatch_matcher_top.sv */
// ---------------------------------------------------------------------------
// hamming_k_mismatch_matcher_top: Hamming-distance k-mismatch matcher
// Loads a pattern into a chain of cells, then streams text through it and
// reports every clean window within the threshold plus an end-of-text summary.
// ---------------------------------------------------------------------------
// A text item's results reach the rsp channel through the registered cell update
// and the tap evaluation into the result queue; the evaluation can stall.
// Throughput: one item per cycle while the result queue has room; the chain
// of cells updates every window in parallel, and the result queue absorbs
// the extra summary item at end of text. Reset: synchronous; windows and
// summary state clear at once, pattern symbols stay undefined until loaded. No clearing pass.
module hamming_k_mismatch_matcher_top #(
   parameter int PATTERN_MAX   = 64,
   parameter int POSITION_BITS = 32
) (
   input  logic                                           clock,
   input  logic                                           reset,
   // input items
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   input  logic [7:0]                                     req_tdata,  // [7:0] symbol
   input  logic                                           req_tuser,  // [0] mode
   input  logic                                           req_tlast,  // last
   // result items
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   // tdata: position [POSITION_BITS-1:0], distance [+7], zero fill
   output logic [((POSITION_BITS+hkm_pkg::CNT_W+7)/8)*8-1:0] rsp_tdata,
   output logic                                           rsp_tuser,  // [0] kind
   output logic                                           rsp_tlast,  // final_res
   // configuration
   input  logic                                           csr_psel,
   input  logic                                           csr_penable,
   input  logic                                           csr_pwrite,
   input  logic [hkm_pkg::CSR_ADDR_W-1:0]                 csr_paddr,
   input  logic [hkm_pkg::CSR_DATA_W-1:0]                 csr_pwdata,
   output logic [hkm_pkg::CSR_DATA_W-1:0]                 csr_prdata,
   output logic                                           csr_pready
);

   localparam int CNT_W   = hkm_pkg::CNT_W;
   localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
   localparam int TDATA_W = ((POSITION_BITS + CNT_W + 7) / 8) * 8;
   localparam int QW      = TDATA_W + 2;

   // configuration registers
   logic [CNT_W-1:0]         plen_ff, mth_ff, xth_ff;
   logic [hkm_pkg::SYM_W-1:0] sep_ff;
   logic                     csr_we;
   hkm_pkg::reg_idx_type     csr_idx;

   // input side
   logic                     req_acc, text_acc, pat_acc;
   logic [LEN_W-1:0]         load_idx_ff, load_idx_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0]         len_eff, len_m1;

   // chain of cells
   hkm_pkg::cell_ctrl_type   cell_ctrl;
   logic [CNT_W-1:0]         cell_count [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]   cell_poison, cell_en, cell_tap, cell_we;

   // evaluation stage
   logic                     sel_valid_ff, sel_valid_in;
   logic                     sel_last_ff;
   logic [POSITION_BITS-1:0] sel_pos_ff;
   logic [CNT_W-1:0]         best_ff, best_in, best_now;
   logic [CNT_W-1:0]         tap_count, sum_dist, sum_cap;
   logic                     tap_poison, matched, best_upd, push;
   logic [POSITION_BITS-1:0] start_pos;
   logic [1:0]               push_cnt;
   logic [QW-1:0]            match_word, sum_word, push_d0, q_out;
   logic                     q_room;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = hkm_pkg::reg_idx_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= 7'd1;
         mth_ff  <= '0;
         xth_ff  <= '0;
         sep_ff  <= 8'hFF;
      end else if (csr_we) begin
         case (csr_idx)
            hkm_pkg::REG_PATTERN_LENGTH:  plen_ff <= csr_pwdata[CNT_W-1:0];
            hkm_pkg::REG_MATCH_THRESHOLD: mth_ff  <= csr_pwdata[CNT_W-1:0];
            hkm_pkg::REG_MAX_THRESHOLD:   xth_ff  <= csr_pwdata[CNT_W-1:0];
            hkm_pkg::REG_SEPARATOR_CODE:  sep_ff  <= csr_pwdata[hkm_pkg::SYM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         hkm_pkg::REG_PATTERN_LENGTH:  csr_prdata = hkm_pkg::CSR_DATA_W'(plen_ff);
         hkm_pkg::REG_MATCH_THRESHOLD: csr_prdata = hkm_pkg::CSR_DATA_W'(mth_ff);
         hkm_pkg::REG_MAX_THRESHOLD:   csr_prdata = hkm_pkg::CSR_DATA_W'(xth_ff);
         hkm_pkg::REG_SEPARATOR_CODE:  csr_prdata = hkm_pkg::CSR_DATA_W'(sep_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // clamp window length to 1..PATTERN_MAX
   always_comb begin
      if (plen_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(plen_ff) > 32'(PATTERN_MAX)) begin
         len_eff = LEN_W'(PATTERN_MAX);
      end else begin
         len_eff = LEN_W'(plen_ff);
      end
      len_m1 = len_eff - LEN_W'(1);
   end

   // ---------------- input side ----------------
   assign req_tready = !sel_valid_ff || push;
   assign req_acc    = req_tvalid && req_tready;
   assign text_acc   = req_acc && (req_tuser == hkm_pkg::MODE_TEXT);
   assign pat_acc    = req_acc && (req_tuser == hkm_pkg::MODE_PATTERN);

   // advance the pattern load index and the text position
   always_comb begin
      load_idx_in = load_idx_ff;
      pos_in      = pos_ff;
      if (pat_acc) begin
         if (load_idx_ff < LEN_W'(PATTERN_MAX)) begin
            load_idx_in = load_idx_ff + LEN_W'(1);
         end
         if (req_tlast) begin
            load_idx_in = '0;
         end
      end
      if (text_acc) begin
         pos_in = req_tlast ? '0 : pos_ff + POSITION_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_idx_ff <= '0;
         pos_ff      <= '0;
      end else begin
         load_idx_ff <= load_idx_in;
         pos_ff      <= pos_in;
      end
   end

   // ---------------- chain of cells ----------------
   always_comb begin
      cell_ctrl.shift  = text_acc;
      cell_ctrl.clear  = push && sel_last_ff;
      cell_ctrl.is_sep = (req_tdata == sep_ff);
      cell_ctrl.sym    = req_tdata;
   end

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      assign cell_en[k]  = (LEN_W'(k) < len_eff);
      assign cell_tap[k] = (LEN_W'(k) == len_m1);
      assign cell_we[k]  = pat_acc && (load_idx_ff == LEN_W'(k));
      if (k == 0) begin : g_head
         hkm_cell #(.IS_HEAD(1'b1)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .en          (cell_en[k]),
            .pat_we      (cell_we[k]),
            .prev_count  ('0),
            .prev_poison (1'b0),
            .count       (cell_count[k]),
            .poison      (cell_poison[k])
         );
      end else begin : g_body
         hkm_cell #(.IS_HEAD(1'b0)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .en          (cell_en[k]),
            .pat_we      (cell_we[k]),
            .prev_count  (cell_count[k-1]),
            .prev_poison (cell_poison[k-1]),
            .count       (cell_count[k]),
            .poison      (cell_poison[k])
         );
      end
   end

   // pick the completed window at the tap cell
   always_comb begin
      tap_count  = '0;
      tap_poison = 1'b0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (cell_tap[k]) begin
            tap_count  = tap_count | cell_count[k];
            tap_poison = tap_poison | cell_poison[k];
         end
      end
   end

   // ---------------- evaluation stage ----------------
   assign push = sel_valid_ff && q_room;

   always_comb begin
      sel_valid_in = sel_valid_ff;
      if (text_acc) begin
         sel_valid_in = 1'b1;
      end else if (push) begin
         sel_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else begin
         sel_valid_ff <= sel_valid_in;
      end
   end

   // hold the item's position and end-of-text flag
   always_ff @(posedge clock) begin
      if (text_acc) begin
         sel_last_ff <= req_tlast;
         sel_pos_ff  <= pos_ff;
      end
   end

   // judge the window, track the best distance, form the result items
   always_comb begin
      matched   = !tap_poison && (tap_count <= mth_ff);
      best_upd  = !tap_poison && (tap_count <= xth_ff) && (tap_count < best_ff);
      best_now  = best_upd ? tap_count : best_ff;
      sum_cap   = (xth_ff == hkm_pkg::CNT_MAX) ? hkm_pkg::CNT_MAX : xth_ff + 1'b1;
      sum_dist  = (best_now != hkm_pkg::CNT_MAX && best_now <= xth_ff) ? best_now : sum_cap;
      start_pos = sel_pos_ff - POSITION_BITS'(len_m1);
      match_word = {~sel_last_ff, hkm_pkg::KIND_MATCH, TDATA_W'({tap_count, start_pos})};
      sum_word   = {1'b1, hkm_pkg::KIND_SUMMARY,
                    TDATA_W'({sum_dist, {POSITION_BITS{1'b0}}})};
      push_d0    = matched ? match_word : sum_word;
      push_cnt   = push ? ({1'b0, matched} + {1'b0, sel_last_ff}) : 2'd0;
      best_in    = best_ff;
      if (push) begin
         best_in = sel_last_ff ? hkm_pkg::CNT_MAX : best_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= hkm_pkg::CNT_MAX;
      end else begin
         best_ff <= best_in;
      end
   end

   // ---------------- result queue ----------------
   hkm_rsp_queue #(.W(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_data0 (push_d0),
      .push_data1 (sum_word),
      .room       (q_room),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (q_out)
   );

   assign rsp_tdata = q_out[TDATA_W-1:0];
   assign rsp_tuser = q_out[TDATA_W];
   assign rsp_tlast = q_out[TDATA_W+1];

   // ---------------- assertions ----------------
   // a summary is always the last result of its input
   a_summary_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == hkm_pkg::KIND_SUMMARY |-> rsp_tlast)
      else $error("summary item without final flag");

   // a stalled evaluation keeps its item
   a_sel_hold: assert property (@(posedge clock) disable iff (reset)
      sel_valid_ff && !push |=> sel_valid_ff && $stable(sel_pos_ff))
      else $error("evaluation stage lost a stalled item");

   // end of text with no new item leaves every window poisoned
   a_clear_poison: assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.clear && !cell_ctrl.shift |=> &cell_poison)
      else $error("windows not cleared after end of text");

   // match reports stay within the threshold
   a_match_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == hkm_pkg::KIND_MATCH
      |-> rsp_tdata[POSITION_BITS +: CNT_W] <= mth_ff)
      else $error("match reported above threshold");

endmodule

/* sv/hkm_cell.sv */
// ---------------------------------------------------------------------------
// hkm_cell: one window cell of the matcher chain
// Holds one pattern symbol and the running mismatch count and separator
// flag of the window that started this many symbols ago.
// ---------------------------------------------------------------------------
module hkm_cell #(
   parameter bit IS_HEAD = 1'b0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hkm_pkg::cell_ctrl_type      ctrl,
   input  logic                        en,
   input  logic                        pat_we,
   input  logic [hkm_pkg::CNT_W-1:0]   prev_count,
   input  logic                        prev_poison,
   output logic [hkm_pkg::CNT_W-1:0]   count,
   output logic                        poison
);

   logic [hkm_pkg::SYM_W-1:0] pat_ff;
   logic [hkm_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      poison_ff, poison_in;
   logic [hkm_pkg::CNT_W-1:0] src_count;
   logic                      src_poison;

   // take the neighbor's window, then compare against the local pattern symbol
   always_comb begin
      count_in   = count_ff;
      poison_in  = poison_ff;
      src_count  = prev_count;
      src_poison = prev_poison;
      if (ctrl.clear && !IS_HEAD) begin
         src_count  = '0;
         src_poison = 1'b1;
      end
      if (ctrl.shift) begin
         count_in  = src_count;
         poison_in = src_poison;
         if (en) begin
            if (ctrl.is_sep) begin
               poison_in = 1'b1;
            end else if (ctrl.sym != pat_ff && src_count != hkm_pkg::CNT_MAX) begin
               count_in = src_count + 1'b1;
            end
         end
      end else if (ctrl.clear) begin
         count_in  = '0;
         poison_in = 1'b1;
      end
   end

   // window state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         poison_ff <= 1'b1;
      end else begin
         count_ff  <= count_in;
         poison_ff <= poison_in;
      end
   end

   // pattern symbol, undefined until loaded
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_ff <= ctrl.sym;
      end
   end

   assign count  = count_ff;
   assign poison = poison_ff;

endmodule

/* sv/hkm_rsp_queue.sv */
// ---------------------------------------------------------------------------
// hkm_rsp_queue: result queue of the matcher
// Small queue that takes up to two result items a cycle while it has room for two
// and hands out one item a cycle while the result channel is ready.
// ---------------------------------------------------------------------------
module hkm_rsp_queue #(
   parameter int W = 42
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   push_cnt,
   input  logic [W-1:0] push_data0,
   input  logic [W-1:0] push_data1,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   localparam int DEPTH = hkm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [W-1:0]     mem [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem[rd_ff];
   assign room      = (count_ff <= CW'(DEPTH - 2));

   // advance pointers and fill level
   always_comb begin
      wr_in    = wr_ff + PTR_W'(push_cnt);
      rd_in    = rd_ff + PTR_W'(pop);
      count_in = count_ff + CW'(push_cnt) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // store up to two items at consecutive slots
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem[wr_ff] <= push_data0;
      end
      if (push_cnt == 2'd2) begin
         mem[wr_ff + PTR_W'(1)] <= push_data1;
      end
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the Hamming k-mismatch matcher
// Loads patterns and streams text sequences, predicts each match report and
// end-of-text summary in a model of the window chain unless a typed row gives
// it, and compares each result item field by field as it leaves the block.
// ---------------------------------------------------------------------------
module tb;

   localparam int SYM_W           = hkm_pkg::SYM_W;
   localparam int CNT_W           = hkm_pkg::CNT_W;
   localparam int CSR_ADDR_W      = hkm_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W      = hkm_pkg::CSR_DATA_W;
   localparam int PAT_MAX         = 64;
   localparam int POS_W           = 32;
   localparam int RSP_W           = ((POS_W + CNT_W + 7) / 8) * 8;
   localparam int ITEM_TARGET     = 650;
   localparam int DRAIN_CYCLES    = 6;
   localparam int PRESSURE_CYCLES = 150;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam logic [CNT_W-1:0] NO_BEST = 7'd127;

   typedef struct packed {
      logic             kind;
      logic [POS_W-1:0] pos;
      logic [CNT_W-1:0] distance;
      logic             fin;
   } report_type;

   typedef enum logic {ROW_CSR, ROW_SYM} row_op_type;

   typedef struct packed {
      row_op_type           op;
      hkm_pkg::reg_idx_type csr;
      logic [7:0]           value;
      logic                 mode;
      logic [SYM_W-1:0]     sym;
      logic                 last;
      logic                 typed;    // expectation given in the row itself
      logic                 has_exp;  // typed row causes one result
      report_type           exp;
   } stim_row_type;

   // block ports
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   wire                   req_tready;
   logic [7:0]            req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  req_tlast   = 1'b0;
   wire                   rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   wire  [RSP_W-1:0]      rsp_tdata;
   wire                   rsp_tuser;
   wire                   rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   wire  [CSR_DATA_W-1:0] csr_prdata;
   wire                   csr_pready;

   // local copy of the window chain and registers
   logic [SYM_W-1:0] pat_mem [PAT_MAX];
   int               load_ptr;
   int               pat_filled;
   logic [CNT_W-1:0] win_cnt [PAT_MAX];
   logic             win_bad [PAT_MAX];
   logic [POS_W-1:0] txt_pos;
   logic [CNT_W-1:0] best_dist;
   logic [6:0]       cfg_len;
   logic [6:0]       cfg_mt;
   logic [6:0]       cfg_maxt;
   logic [7:0]       cfg_sep;

   report_type   awaited_reports [$];
   report_type   fresh [2];
   int           fresh_n;
   stim_row_type directed_rows [$];

   int   mismatches  = 0;
   int   items_sent  = 0;
   int   idle_cycles = 0;
   int   rsp_hold    = 0;
   logic quiet       = 1'b0;
   logic hold_rsp    = 1'b0;
   logic hold_done   = 1'b0;
   bit   burst_mode  = 1'b0;

   hamming_k_mismatch_matcher_top #(
      .PATTERN_MAX   (PAT_MAX),
      .POSITION_BITS (POS_W)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // stimulus rows
   function automatic stim_row_type csr_row(hkm_pkg::reg_idx_type r, logic [7:0] v);
      stim_row_type row;
      row       = '0;
      row.op    = ROW_CSR;
      row.csr   = r;
      row.value = v;
      return row;
   endfunction

   function automatic stim_row_type sym_row(logic mode, logic [7:0] sym, logic last);
      stim_row_type row;
      row      = '0;
      row.op   = ROW_SYM;
      row.mode = mode;
      row.sym  = sym;
      row.last = last;
      return row;
   endfunction

   function automatic stim_row_type typed_row(logic mode, logic [7:0] sym, logic last,
                                              logic has, logic kind,
                                              logic [POS_W-1:0] pos,
                                              logic [CNT_W-1:0] distance);
      stim_row_type row;
      row              = sym_row(mode, sym, last);
      row.typed        = 1'b1;
      row.has_exp      = has;
      row.exp.kind     = kind;
      row.exp.pos      = pos;
      row.exp.distance = distance;
      row.exp.fin      = 1'b1;
      return row;
   endfunction

   // window length as the block uses it
   function automatic int span(logic [6:0] l);
      if (l == 0)
         return 1;
      if (l > PAT_MAX)
         return PAT_MAX;
      return l;
   endfunction

   task automatic restart_text();
      for (int k = 0; k < PAT_MAX; k++) begin
         win_cnt[k] = '0;
         win_bad[k] = 1'b1;
      end
      txt_pos   = '0;
      best_dist = NO_BEST;
   endtask

   // Advance the window chain by one item and collect the reports it causes
   task automatic predict_window_scores(input logic mode, input logic [7:0] sym,
                                        input logic last);
      int               el;
      int               cap;
      logic [CNT_W-1:0] c;
      report_type       r;
      fresh_n = 0;
      if (mode == hkm_pkg::MODE_PATTERN) begin
         if (load_ptr < PAT_MAX) begin
            pat_mem[load_ptr] = sym;
            load_ptr++;
            if (load_ptr > pat_filled)
               pat_filled = load_ptr;
         end
         if (last)
            load_ptr = 0;
      end else begin
         el = span(cfg_len);
         // shift every open window one cell down the chain
         for (int k = PAT_MAX - 1; k > 0; k--) begin
            win_cnt[k] = win_cnt[k-1];
            win_bad[k] = win_bad[k-1];
         end
         win_cnt[0] = '0;
         win_bad[0] = 1'b0;
         for (int k = 0; k < el; k++) begin
            if (sym == cfg_sep)
               win_bad[k] = 1'b1;
            else if (sym != pat_mem[k] && win_cnt[k] != hkm_pkg::CNT_MAX)
               win_cnt[k] = win_cnt[k] + 1'b1;
         end
         // judge the window that completes here
         if (!win_bad[el-1]) begin
            c = win_cnt[el-1];
            if (c <= cfg_mt) begin
               r.kind     = hkm_pkg::KIND_MATCH;
               r.pos      = txt_pos - POS_W'(el - 1);
               r.distance = c;
               r.fin      = 1'b0;
               fresh[fresh_n] = r;
               fresh_n++;
            end
            if (c <= cfg_maxt && c < best_dist)
               best_dist = c;
         end
         txt_pos = txt_pos + 1'b1;
         // end of text: summary, then back to the empty chain
         if (last) begin
            if (best_dist != NO_BEST && best_dist <= cfg_maxt) begin
               r.distance = best_dist;
            end else begin
               cap = int'(cfg_maxt) + 1;
               if (cap > 127)
                  cap = 127;
               r.distance = CNT_W'(cap);
            end
            r.kind = hkm_pkg::KIND_SUMMARY;
            r.pos  = '0;
            r.fin  = 1'b0;
            fresh[fresh_n] = r;
            fresh_n++;
            restart_text();
         end
         if (fresh_n > 0)
            fresh[fresh_n-1].fin = 1'b1;
      end
   endtask

   // Offer one item, hold it until accepted, then queue what it should cause
   task automatic send_item(input stim_row_type row);
      int gap;
      if (!quiet && !burst_mode && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.mode;
      req_tdata  <= row.sym;
      req_tlast  <= row.last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict_window_scores(row.mode, row.sym, row.last);
      if (row.typed) begin
         if (row.has_exp)
            awaited_reports.push_back(row.exp);
      end else begin
         for (int i = 0; i < fresh_n; i++)
            awaited_reports.push_back(fresh[i]);
      end
   endtask

   // Setup and access cycle of one register write
   task automatic csr_write(input hkm_pkg::reg_idx_type r, input logic [7:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (r)
         hkm_pkg::REG_PATTERN_LENGTH:  cfg_len  = v[6:0];
         hkm_pkg::REG_MATCH_THRESHOLD: cfg_mt   = v[6:0];
         hkm_pkg::REG_MAX_THRESHOLD:   cfg_maxt = v[6:0];
         hkm_pkg::REG_SEPARATOR_CODE:  cfg_sep  = v;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Hold the input, let every awaited report arrive, then let the pipe settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_pattern(input int n, input bit close);
      for (int i = 0; i < n; i++)
         send_item(sym_row(hkm_pkg::MODE_PATTERN, 8'($urandom_range(0, 255)),
                           close && i == n - 1));
   endtask

   // One text sequence: mostly near copies of the pattern, some noise
   task automatic feed_text(input int el, input int tl);
      logic [7:0] chunk [$];
      logic [7:0] s;
      int         emitted;
      int         r;
      emitted = 0;
      while (emitted < tl) begin
         r = $urandom_range(0, 19);
         chunk.delete();
         if (r < 12) begin
            for (int j = 0; j < el; j++)
               chunk.push_back(pat_mem[j]);
            repeat ($urandom_range(0, 2))
               chunk[$urandom_range(0, el - 1)] = 8'($urandom_range(0, 255));
         end else if (r < 16) begin
            repeat ($urandom_range(1, 4))
               chunk.push_back(8'($urandom_range(0, 255)));
         end else if (r < 19) begin
            chunk.push_back(cfg_sep);
         end else begin
            send_item(sym_row(hkm_pkg::MODE_PATTERN, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1))));
         end
         while (chunk.size() != 0 && emitted < tl) begin
            s = chunk.pop_front();
            send_item(sym_row(hkm_pkg::MODE_TEXT, s, emitted == tl - 1));
            emitted++;
         end
      end
   endtask

   // Receiver: random stalls, one long hold-off, none near the end
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else if (hold_rsp && !hold_done) begin
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
         rsp_hold   <= PRESSURE_CYCLES - 1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= $urandom_range(0, 16);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each accepted result item with the oldest awaited report
   always @(posedge clock) begin : check_results
      report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_reports.size() == 0) begin
            $error("unexpected result item: kind %0d position %0d distance %0d",
                   rsp_tuser, rsp_tdata[POS_W-1:0], rsp_tdata[POS_W+CNT_W-1:POS_W]);
            mismatches++;
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[POS_W-1:0] !== want.pos) begin
               $error("position: expected %0d, got %0d", want.pos, rsp_tdata[POS_W-1:0]);
               mismatches++;
            end
            if (rsp_tdata[POS_W+CNT_W-1:POS_W] !== want.distance) begin
               $error("distance: expected %0d, got %0d", want.distance,
                      rsp_tdata[POS_W+CNT_W-1:POS_W]);
               mismatches++;
            end
            if (rsp_tlast !== want.fin) begin
               $error("final_res: expected %0d, got %0d", want.fin, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int rand_start;
      int phase;
      int plen;
      int lim;
      int new_len;
      int new_mt;
      int new_maxt;
      int new_sep;
      int r;
      int el;
      int tl;
      bit do_load;
      bit pressing;
      bit pressure_sent;

      // model state after reset
      for (int k = 0; k < PAT_MAX; k++)
         pat_mem[k] = '0;
      load_ptr   = 0;
      pat_filled = 0;
      cfg_len    = 7'd1;
      cfg_mt     = 7'd0;
      cfg_maxt   = 7'd0;
      cfg_sep    = 8'hFF;
      restart_text();
      pressure_sent = 1'b0;

      // directed table: reset values, extremes, separator, summary cap
      directed_rows.push_back(typed_row(hkm_pkg::MODE_TEXT, 8'hFF, 1'b1, 1'b1,
                                        hkm_pkg::KIND_SUMMARY, 0, 7'd1));
      directed_rows.push_back(typed_row(hkm_pkg::MODE_PATTERN, 8'h00, 1'b1, 1'b0,
                                        hkm_pkg::KIND_MATCH, 0, 7'd0));
      directed_rows.push_back(typed_row(hkm_pkg::MODE_TEXT, 8'h00, 1'b0, 1'b1,
                                        hkm_pkg::KIND_MATCH, 0, 7'd0));
      directed_rows.push_back(typed_row(hkm_pkg::MODE_TEXT, 8'hFF, 1'b0, 1'b0,
                                        hkm_pkg::KIND_MATCH, 0, 7'd0));
      directed_rows.push_back(typed_row(hkm_pkg::MODE_TEXT, 8'h01, 1'b1, 1'b1,
                                        hkm_pkg::KIND_SUMMARY, 0, 7'd0));
      directed_rows.push_back(csr_row(hkm_pkg::REG_PATTERN_LENGTH, 8'd4));
      directed_rows.push_back(csr_row(hkm_pkg::REG_MATCH_THRESHOLD, 8'd1));
      directed_rows.push_back(csr_row(hkm_pkg::REG_MAX_THRESHOLD, 8'd2));
      directed_rows.push_back(csr_row(hkm_pkg::REG_SEPARATOR_CODE, 8'h80));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_PATTERN, 8'h00, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_PATTERN, 8'hFF, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_PATTERN, 8'hA5, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_PATTERN, 8'h5A, 1'b1));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_TEXT, 8'h00, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_TEXT, 8'hFF, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_TEXT, 8'hA5, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_TEXT, 8'h5A, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_TEXT, 8'h00, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_TEXT, 8'hFF, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_TEXT, 8'hA5, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_TEXT, 8'h5B, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_TEXT, 8'h80, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_TEXT, 8'h5A, 1'b1));
      // length zero acts as one, summary cap saturates
      directed_rows.push_back(csr_row(hkm_pkg::REG_PATTERN_LENGTH, 8'd0));
      directed_rows.push_back(csr_row(hkm_pkg::REG_MATCH_THRESHOLD, 8'd127));
      directed_rows.push_back(csr_row(hkm_pkg::REG_MAX_THRESHOLD, 8'd127));
      directed_rows.push_back(csr_row(hkm_pkg::REG_SEPARATOR_CODE, 8'h00));
      directed_rows.push_back(typed_row(hkm_pkg::MODE_TEXT, 8'h00, 1'b1, 1'b1,
                                        hkm_pkg::KIND_SUMMARY, 0, 7'd127));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_TEXT, 8'h01, 1'b0));
      directed_rows.push_back(sym_row(hkm_pkg::MODE_TEXT, 8'hFF, 1'b1));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_CSR) begin
            wait_drained();
            csr_write(directed_rows[i].csr, directed_rows[i].value);
         end else begin
            send_item(directed_rows[i]);
         end
      end

      // random phases: settings, optional pattern load, text sequences
      rand_start = items_sent;
      phase      = 0;
      while (items_sent - rand_start < ITEM_TARGET) begin
         if (items_sent - rand_start > ITEM_TARGET * 85 / 100)
            quiet <= 1'b1;
         wait_drained();

         do_load = (phase == 0) || ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 70)
            plen = $urandom_range(1, 8);
         else if (r < 85)
            plen = $urandom_range(9, 40);
         else if (r < 93)
            plen = PAT_MAX;
         else
            plen = $urandom_range(PAT_MAX + 1, PAT_MAX + 8);
         // pattern overflow with the largest length value early on
         if (phase == 2) begin
            do_load = 1'b1;
            plen    = PAT_MAX + 6;
         end

         lim = pat_filled;
         if (do_load && ((plen > PAT_MAX ? PAT_MAX : plen) > lim))
            lim = (plen > PAT_MAX) ? PAT_MAX : plen;

         // never widen the window past the pattern entries written so far
         r = $urandom_range(0, 9);
         if (r < 7)
            new_len = do_load ? ((plen > PAT_MAX) ? PAT_MAX : plen) : $urandom_range(1, lim);
         else if (r == 7)
            new_len = $urandom_range(1, lim);
         else if (r == 8)
            new_len = 0;
         else
            new_len = (lim == PAT_MAX) ? $urandom_range(PAT_MAX + 1, 127) : lim;
         if (phase == 2)
            new_len = 127;

         r = $urandom_range(0, 9);
         new_mt = (r < 6) ? $urandom_range(0, 3) : (r < 8) ? $urandom_range(0, 64) :
                  (r == 8) ? 127 : 64;
         r = $urandom_range(0, 9);
         new_maxt = (r < 6) ? $urandom_range(0, 3) : (r < 8) ? $urandom_range(0, 64) :
                    (r == 8) ? 127 : 64;
         r = $urandom_range(0, 9);
         new_sep = (r < 5) ? 255 : (r < 8) ? $urandom_range(0, 255) : 0;

         // report every window while the receiver holds off
         pressing = !pressure_sent && (items_sent - rand_start >= 250);
         if (pressing)
            new_mt = 127;

         csr_write(hkm_pkg::REG_PATTERN_LENGTH, 8'(new_len));
         csr_write(hkm_pkg::REG_MATCH_THRESHOLD, 8'(new_mt));
         csr_write(hkm_pkg::REG_MAX_THRESHOLD, 8'(new_maxt));
         csr_write(hkm_pkg::REG_SEPARATOR_CODE, 8'(new_sep));

         if (do_load)
            load_pattern(plen, $urandom_range(0, 9) != 0);

         if (pressing) begin
            burst_mode    = 1'b1;
            hold_rsp     <= 1'b1;
            pressure_sent = 1'b1;
         end

         repeat ($urandom_range(1, 3)) begin
            el = span(cfg_len);
            tl = el + $urandom_range(0, el + 8);
            if (pressing && tl < 80)
               tl = 80;
            feed_text(el, tl);
         end
         burst_mode = 1'b0;
         phase++;
      end

      // drain and report
      wait_drained();
      if (mismatches == 0 && awaited_reports.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
